FILE: src/nrt_pkg.sv
// ---------------------------------------------------------------------------
// nrt_pkg: shared types and codes for the nested range table
// Request and response words, operation and status codes, controller states
// and the flag group that the walk unit hands back to the controller.
// ---------------------------------------------------------------------------
package nrt_pkg;

  localparam int DEFAULT_ENTRIES = 1024;
  localparam int ENTRY_INDEX_W   = 11;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_FENCE = 2'd1,
    REQ_POP   = 2'd2,
    REQ_FIND  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_OPEN  = 2'd2,
    STATUS_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [15:0] source_id;
    logic [31:0] run_pos;
    logic [31:0] text_pos;
  } req_word_t;

  typedef struct packed {
    status_t                  status;
    logic                     hit;
    logic [15:0]              found_source;
    logic [31:0]              found_syntax_start;
    logic [31:0]              found_syntax_stop;
    logic [ENTRY_INDEX_W-1:0] entry_index;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CUR_WAIT,
    S_APPEND,
    S_WALK_ADDR,
    S_WALK_EVAL,
    S_DONE
  } state_t;

  // live: walk may visit entry k; contains: entry k holds the position;
  // halt: miss on an entry still open (skip of zero)
  typedef struct packed {
    logic live;
    logic contains;
    logic halt;
  } walk_flags_t;

endpackage

FILE: src/nrt_ram.sv
// ---------------------------------------------------------------------------
// nrt_ram: range table storage
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module nrt_ram import nrt_pkg::*; #(
  parameter int DEPTH = DEFAULT_ENTRIES,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nrt_walk.sv
// ---------------------------------------------------------------------------
// nrt_walk: one step of the skip-count walk
// Forms the entry address, tests the position against the entry's span and
// computes the next base, offset and limit.
// ---------------------------------------------------------------------------
module nrt_walk import nrt_pkg::*; #(
  parameter int CW = 11,
  parameter int WW = CW + 2
) (
  input  logic [WW-1:0] base,
  input  logic [WW-1:0] ofs,
  input  logic [CW-1:0] limit,
  input  logic [CW-1:0] count,
  input  logic [CW-1:0] skip,
  input  logic [31:0]   pos,
  input  logic [31:0]   span_start,
  input  logic [31:0]   span_stop,
  output logic [WW-1:0] k,
  output logic [WW-1:0] base_next,
  output logic [WW-1:0] ofs_next,
  output logic [CW-1:0] limit_next,
  output walk_flags_t   flags
);

  logic contains;

  assign k        = base + ofs;
  assign contains = (pos >= span_start) && (pos < span_stop);

  assign flags.live     = (ofs < WW'(limit)) && (k < WW'(count));
  assign flags.contains = contains;
  assign flags.halt     = !contains && (skip == '0);

  // hit: descend into the entry's subtree; miss: jump over it
  assign base_next  = contains ? k : base;
  assign ofs_next   = contains ? WW'(1) : ofs + WW'(skip);
  assign limit_next = contains ? skip : limit;

endmodule

FILE: src/nested_range_table_core.sv
// ---------------------------------------------------------------------------
// nested_range_table_core: append-only table of nested position ranges
// Push, fence and pop build a flattened range tree; find returns the
// innermost range that holds an execution position.
// ---------------------------------------------------------------------------
// One request word is handled at a time; req_stall is high from acceptance
// until its response word is loaded into the output register (a waiting
// response does not block the next request). After decode, push goes
// through append and done; pop through a read of the open entry and done;
// fence through that read, an append when it adds a sibling, and done; a
// full push or a fence or pop with no open range goes straight to done.
// Find alternates an address step and an evaluate step for each table entry
// the walk visits, then goes to done. Every entry access is a registered
// read from the single table memory, and each walk step is one read plus
// one pass through the walk unit. The table has no clearing pass; entries
// are only read below the fill count.
// ---------------------------------------------------------------------------
module nested_range_table_core import nrt_pkg::*; #(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  // index, count (0..ENTRIES) and walk offset widths
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = CW + 2;

  // one table entry; parent_none marks a top-level range
  typedef struct packed {
    logic [CW-1:0] skip;
    logic          parent_none;
    logic [IW-1:0] parent;
    logic [31:0]   exec_start;
    logic [31:0]   exec_stop;
    logic [15:0]   source;
    logic [31:0]   syntax_start;
    logic [31:0]   syntax_stop;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // controller state
  state_t        state, state_next;
  req_word_t     cur_req, cur_req_next;
  logic [CW-1:0] count, count_next;          // entries written so far
  logic          open_none, open_none_next;  // no open range
  logic [IW-1:0] open_idx, open_idx_next;

  // parent picked for the entry about to be appended
  logic          app_none, app_none_next;
  logic [IW-1:0] app_parent, app_parent_next;

  // walk registers
  logic [WW-1:0] base, base_next;
  logic [WW-1:0] ofs, ofs_next;
  logic [CW-1:0] limit, limit_next;

  // response being assembled
  status_t       res_status, res_status_next;
  logic          res_hit, res_hit_next;
  logic [CW-1:0] res_idx, res_idx_next;
  logic [15:0]   res_src, res_src_next;
  logic [31:0]   res_start, res_start_next;
  logic [31:0]   res_stop, res_stop_next;

  // output register
  logic          rsp_valid_next;
  rsp_word_t     rsp_next;

  // table port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wentry, rentry;
  logic [EW-1:0] rdata;

  // walk unit
  logic [WW-1:0] wk, w_base, w_ofs;
  logic [CW-1:0] w_limit;
  walk_flags_t   wflags;

  logic          full;

  assign rentry    = entry_t'(rdata);
  assign full      = (count == CW'(ENTRIES));
  assign req_stall = (state != S_IDLE);

  nrt_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (EW'(wentry)),
    .raddr (raddr),
    .rdata (rdata)
  );

  nrt_walk #(
    .CW (CW),
    .WW (WW)
  ) u_walk (
    .base       (base),
    .ofs        (ofs),
    .limit      (limit),
    .count      (count),
    .skip       (rentry.skip),
    .pos        (cur_req.run_pos),
    .span_start (rentry.exec_start),
    .span_stop  (rentry.exec_stop),
    .k          (wk),
    .base_next  (w_base),
    .ofs_next   (w_ofs),
    .limit_next (w_limit),
    .flags      (wflags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      open_none <= 1'b1;
      open_idx  <= '1;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      open_none <= open_none_next;
      open_idx  <= open_idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_req    <= cur_req_next;
    app_none   <= app_none_next;
    app_parent <= app_parent_next;
    base       <= base_next;
    ofs        <= ofs_next;
    limit      <= limit_next;
    res_status <= res_status_next;
    res_hit    <= res_hit_next;
    res_idx    <= res_idx_next;
    res_src    <= res_src_next;
    res_start  <= res_start_next;
    res_stop   <= res_stop_next;
    rsp        <= rsp_next;
  end

  always_comb begin
    state_next      = state;
    cur_req_next    = cur_req;
    count_next      = count;
    open_none_next  = open_none;
    open_idx_next   = open_idx;
    app_none_next   = app_none;
    app_parent_next = app_parent;
    base_next       = base;
    ofs_next        = ofs;
    limit_next      = limit;
    res_status_next = res_status;
    res_hit_next    = res_hit;
    res_idx_next    = res_idx;
    res_src_next    = res_src;
    res_start_next  = res_start;
    res_stop_next   = res_stop;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    we              = 1'b0;
    waddr           = '0;
    wentry          = '0;
    raddr           = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_req_next = req;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_next = STATUS_OK;
        res_hit_next    = 1'b0;
        res_idx_next    = CW'(ENTRIES);
        res_src_next    = '0;
        res_start_next  = '0;
        res_stop_next   = '0;
        unique case (cur_req.req_type)
          REQ_PUSH: begin
            if (full) begin
              res_status_next = STATUS_FULL;
              state_next      = S_DONE;
            end else begin
              app_none_next   = open_none;
              app_parent_next = open_idx;
              state_next      = S_APPEND;
            end
          end
          REQ_FENCE, REQ_POP: begin
            if (open_none) begin
              res_status_next = STATUS_NO_OPEN;
              state_next      = S_DONE;
            end else begin
              raddr      = open_idx;
              state_next = S_CUR_WAIT;
            end
          end
          REQ_FIND: begin
            base_next  = '0;
            ofs_next   = '0;
            limit_next = count;
            state_next = S_WALK_ADDR;
          end
        endcase
      end

      // open entry is on the read port
      S_CUR_WAIT: begin
        if ((cur_req.req_type == REQ_FENCE) && (rentry.source != cur_req.source_id)) begin
          res_status_next = STATUS_MISMATCH;
          state_next      = S_DONE;
        end else begin
          // close: skip spans the subtree written so far
          we                 = 1'b1;
          waddr              = open_idx;
          wentry             = rentry;
          wentry.skip        = count - CW'(open_idx);
          wentry.exec_stop   = cur_req.run_pos;
          wentry.syntax_stop = cur_req.text_pos;
          if (cur_req.req_type == REQ_POP) begin
            open_none_next = rentry.parent_none;
            open_idx_next  = rentry.parent;
            res_idx_next   = CW'(open_idx);
            state_next     = S_DONE;
          end else if (full) begin
            // closed, but stays the open range
            res_status_next = STATUS_FULL;
            state_next      = S_DONE;
          end else begin
            app_none_next   = rentry.parent_none;
            app_parent_next = rentry.parent;
            state_next      = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        we                  = 1'b1;
        waddr               = count[IW-1:0];
        wentry.skip         = '0;
        wentry.parent_none  = app_none;
        wentry.parent       = app_parent;
        wentry.exec_start   = cur_req.run_pos;
        wentry.exec_stop    = cur_req.run_pos;
        wentry.source       = cur_req.source_id;
        wentry.syntax_start = cur_req.text_pos;
        wentry.syntax_stop  = cur_req.text_pos;
        open_none_next      = 1'b0;
        open_idx_next       = count[IW-1:0];
        count_next          = count + CW'(1);
        res_idx_next        = count;
        state_next          = S_DONE;
      end

      S_WALK_ADDR: begin
        if (wflags.live) begin
          raddr      = wk[IW-1:0];
          state_next = S_WALK_EVAL;
        end else begin
          state_next = S_DONE;
        end
      end

      S_WALK_EVAL: begin
        if (wflags.contains) begin
          res_hit_next   = 1'b1;
          res_idx_next   = wk[CW-1:0];
          res_src_next   = rentry.source;
          res_start_next = rentry.syntax_start;
          res_stop_next  = rentry.syntax_stop;
        end
        base_next  = w_base;
        ofs_next   = w_ofs;
        limit_next = w_limit;
        // an open entry has no skip: end the walk there
        state_next = wflags.halt ? S_DONE : S_WALK_ADDR;
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next              = 1'b1;
          rsp_next.status             = res_status;
          rsp_next.hit                = res_hit;
          rsp_next.found_source       = res_src;
          rsp_next.found_syntax_start = res_start;
          rsp_next.found_syntax_stop  = res_stop;
          rsp_next.entry_index        = ENTRY_INDEX_W'(res_idx);
          state_next                  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // open range always lies inside the written part of the table
  a_open_written: assert property (@(posedge clk) disable iff (rst)
    !open_none |-> (CW'(open_idx) < count))
    else $error("open range index beyond fill count");

  // walk only reads written entries
  a_walk_written: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_EVAL) |-> (wk < WW'(count)))
    else $error("walk read past fill count");

  // fill count moves only by one append
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      (($past(state) == S_APPEND) && (count == $past(count) + CW'(1))))
    else $error("fill count changed outside append");

  // a new response comes only from the final state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(rsp_valid)) |-> ($past(state) == S_DONE))
    else $error("response raised outside completion");

endmodule

FILE: bench/tb_nested_range_table_core.sv
// ---------------------------------------------------------------------------
// tb_nested_range_table_core: self-checking bench for the range table core
// Sends push, fence, pop and find words in bursts with random gaps, stalls
// the response side on its own pattern, and checks each response word field
// by field against a listed answer or the bench's own table model.
// ---------------------------------------------------------------------------
module tb_nested_range_table_core;
  import nrt_pkg::*;

  localparam int TBL_ENTRIES = DEFAULT_ENTRIES;
  localparam logic [31:0] NO_IDX = 32'hFFFF_FFFF;
  // entry_index reported when there is no entry to name
  localparam logic [ENTRY_INDEX_W-1:0] NONE_RSP = ENTRY_INDEX_W'(TBL_ENTRIES);
  localparam int BUILD_WORDS  = 120;
  localparam int RANDOM_WORDS = 506;
  // a find over a full table may visit every entry
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 24;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_RARE,
    STALL_HOLD
  } stall_mode_t;

  // one directed row: the request word and, where it is obvious, its answer
  typedef struct packed {
    req_word_t word;
    logic      typed;
    rsp_word_t want;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  nested_range_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Table model. Parents and the open index are kept 32 bits wide so that
  // all ones can stand for "no range".
  // ---------------------------------------------------------------------------
  logic [31:0] tbl_skip       [TBL_ENTRIES];
  logic [31:0] tbl_parent     [TBL_ENTRIES];
  logic [31:0] tbl_exec_start [TBL_ENTRIES];
  logic [31:0] tbl_exec_stop  [TBL_ENTRIES];
  logic [15:0] tbl_source     [TBL_ENTRIES];
  logic [31:0] tbl_syn_start  [TBL_ENTRIES];
  logic [31:0] tbl_syn_stop   [TBL_ENTRIES];
  logic [31:0] fill_count = '0;
  logic [31:0] open_idx   = NO_IDX;

  rsp_word_t   pending_rsp_q [$];
  stim_row_t   directed_rows [$];
  int          err_count = 0;

  // new entries start open: empty exec span, skip of zero
  function automatic logic [31:0] append_range(input logic [15:0] src,
                                               input logic [31:0] epos, spos, parent);
    logic [31:0] k;
    k = fill_count;
    if (k >= TBL_ENTRIES) return NO_IDX;
    tbl_skip[k]       = '0;
    tbl_parent[k]     = parent;
    tbl_exec_start[k] = epos;
    tbl_exec_stop[k]  = epos;
    tbl_source[k]     = src;
    tbl_syn_start[k]  = spos;
    tbl_syn_stop[k]   = spos;
    fill_count        = k + 1;
    return k;
  endfunction

  // skip covers everything appended since the entry itself
  function automatic void close_range(input logic [31:0] cur, epos, spos);
    tbl_skip[cur]      = fill_count - cur;
    tbl_exec_stop[cur] = epos;
    tbl_syn_stop[cur]  = spos;
  endfunction

  function automatic rsp_word_t next_rsp(input req_word_t w);
    rsp_word_t   r;
    logic [31:0] cur, k, base, step, span, hit_idx;
    bit          walking;
    r             = '0;
    r.status      = STATUS_OK;
    r.entry_index = NONE_RSP;
    cur           = open_idx;
    case (w.req_type)
      REQ_PUSH: begin
        k = append_range(w.source_id, w.run_pos, w.text_pos, cur);
        if (k == NO_IDX) r.status = STATUS_FULL;
        else begin
          open_idx      = k;
          r.entry_index = k[ENTRY_INDEX_W-1:0];
        end
      end
      REQ_FENCE: begin
        if (cur == NO_IDX) r.status = STATUS_NO_OPEN;
        else if (tbl_source[cur] != w.source_id) r.status = STATUS_MISMATCH;
        else begin
          // the close sticks even when the table has no room for the sibling
          close_range(cur, w.run_pos, w.text_pos);
          k = append_range(w.source_id, w.run_pos, w.text_pos, tbl_parent[cur]);
          if (k == NO_IDX) r.status = STATUS_FULL;
          else begin
            open_idx      = k;
            r.entry_index = k[ENTRY_INDEX_W-1:0];
          end
        end
      end
      REQ_POP: begin
        if (cur == NO_IDX) r.status = STATUS_NO_OPEN;
        else begin
          close_range(cur, w.run_pos, w.text_pos);
          open_idx      = tbl_parent[cur];
          r.entry_index = cur[ENTRY_INDEX_W-1:0];
        end
      end
      default: begin
        // find: descend into a hit, hop over a miss by its skip; a miss on an
        // open entry (skip 0) ends the walk
        hit_idx = NO_IDX;
        base    = '0;
        step    = '0;
        span    = fill_count;
        walking = 1'b1;
        while (walking && step < span) begin
          k = base + step;
          if (k >= fill_count) walking = 1'b0;
          else if (w.run_pos >= tbl_exec_start[k] && w.run_pos < tbl_exec_stop[k]) begin
            hit_idx = k;
            base    = k;
            span    = tbl_skip[k];
            step    = 32'd1;
          end else if (tbl_skip[k] == '0) walking = 1'b0;
          else step = step + tbl_skip[k];
        end
        if (hit_idx != NO_IDX) begin
          r.hit                = 1'b1;
          r.found_source       = tbl_source[hit_idx];
          r.found_syntax_start = tbl_syn_start[hit_idx];
          r.found_syntax_stop  = tbl_syn_stop[hit_idx];
          r.entry_index        = hit_idx[ENTRY_INDEX_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random words. Mostly well-formed nesting on rising positions, so that
  // finds land inside real ranges; the rest is noise on every field.
  // ---------------------------------------------------------------------------
  logic [31:0] exec_cursor = 32'd100;
  logic [31:0] syn_cursor  = 32'd1000;

  function automatic req_word_t make_word(input bit filling);
    req_word_t   w;
    int unsigned depth, roll, push_w, pop_w;
    logic [31:0] walk;
    w.req_type  = REQ_FIND;
    w.source_id = 16'($urandom);
    w.run_pos   = exec_cursor;
    w.text_pos  = syn_cursor;
    depth = 0;
    walk  = open_idx;
    while (walk != NO_IDX && depth < 64) begin
      depth++;
      walk = tbl_parent[walk];
    end
    if (!filling && $urandom_range(0, 99) < 15) begin
      w.req_type = req_type_t'($urandom_range(0, 3));
      w.run_pos  = $urandom;
      w.text_pos = $urandom;
      return w;
    end
    roll   = $urandom_range(0, 99);
    push_w = (depth >= 8) ? 10 : (filling ? 50 : 30);
    pop_w  = (depth >= 8) ? 50 : 25;
    if (open_idx == NO_IDX) w.req_type = (roll < (filling ? 90 : 60)) ? REQ_PUSH : REQ_FIND;
    else if (roll < push_w) w.req_type = REQ_PUSH;
    else if (roll < push_w + pop_w) w.req_type = REQ_POP;
    else if (roll < push_w + pop_w + 20) begin
      w.req_type  = REQ_FENCE;
      w.source_id = tbl_source[open_idx];
    end else w.req_type = REQ_FIND;
    if (w.req_type == REQ_FIND) w.run_pos = $urandom_range(exec_cursor + 16, 0);
    else begin
      exec_cursor = exec_cursor + $urandom_range(1, 48);
      syn_cursor  = syn_cursor + $urandom_range(0, 40);
    end
    return w;
  endfunction

  task automatic add_row(input req_type_t op, input logic [15:0] src,
                         input logic [31:0] epos, spos, input bit typed,
                         input status_t st, input logic [ENTRY_INDEX_W-1:0] idx);
    stim_row_t row;
    row                  = '0;
    row.word.req_type    = op;
    row.word.source_id   = src;
    row.word.run_pos     = epos;
    row.word.text_pos    = spos;
    row.typed            = typed;
    row.want.status      = st;
    row.want.entry_index = idx;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Request side: hold the word until it is taken, predict on the taking
  // edge, then either go straight on or drop valid for a random gap.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_word(input stim_row_t row);
    rsp_word_t   model_rsp;
    int unsigned gap;
    req       <= row.word;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    model_rsp = next_rsp(row.word);
    pending_rsp_q.push_back(row.typed ? row.want : model_rsp);
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 9);
      burst_left = $urandom_range(0, 24);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else burst_left--;
  endtask

  // ---------------------------------------------------------------------------
  // Response side: check each word taken, then pick the next stall value.
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  rsp_word_t   want_rsp;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: response word %h with none expected", $time, rsp);
          err_count++;
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          if (rsp.status !== want_rsp.status) begin
            $display("%0t: status expected %0d got %0d", $time, want_rsp.status, rsp.status);
            err_count++;
          end
          if (rsp.hit !== want_rsp.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, want_rsp.hit, rsp.hit);
            err_count++;
          end
          if (rsp.found_source !== want_rsp.found_source) begin
            $display("%0t: found_source expected %h got %h", $time,
                     want_rsp.found_source, rsp.found_source);
            err_count++;
          end
          if (rsp.found_syntax_start !== want_rsp.found_syntax_start) begin
            $display("%0t: found_syntax_start expected %h got %h", $time,
                     want_rsp.found_syntax_start, rsp.found_syntax_start);
            err_count++;
          end
          if (rsp.found_syntax_stop !== want_rsp.found_syntax_stop) begin
            $display("%0t: found_syntax_stop expected %h got %h", $time,
                     want_rsp.found_syntax_stop, rsp.found_syntax_stop);
            err_count++;
          end
          if (rsp.entry_index !== want_rsp.entry_index) begin
            $display("%0t: entry_index expected %0d got %0d", $time,
                     want_rsp.entry_index, rsp.entry_index);
            err_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
      end else stall_left--;
      case (stall_mode)
        STALL_NONE: rsp_stall <= 1'b0;
        STALL_HALF: rsp_stall <= 1'($urandom_range(0, 1));
        STALL_RARE: rsp_stall <= ($urandom_range(0, 5) == 0);
        default:    rsp_stall <= 1'b1;
      endcase
    end
  end

  // no word moving on either side for too long means the block is stuck
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    // empty table, then a small tree whose answers can be read off directly
    add_row(REQ_FIND,  16'h0000, 32'd7,         32'd0,         1'b1, STATUS_OK,       NONE_RSP);
    add_row(REQ_POP,   16'h0000, 32'd3,         32'd3,         1'b1, STATUS_NO_OPEN,  NONE_RSP);
    add_row(REQ_FENCE, 16'h0005, 32'd4,         32'd4,         1'b1, STATUS_NO_OPEN,  NONE_RSP);
    add_row(REQ_PUSH,  16'hFFFF, 32'd0,         32'd0,         1'b1, STATUS_OK,       11'd0);
    add_row(REQ_PUSH,  16'h0000, 32'd10,        32'd100,       1'b1, STATUS_OK,       11'd1);
    // open entry ahead of the query: the walk stops there
    add_row(REQ_FIND,  16'h0000, 32'd5,         32'hFFFF_FFFF, 1'b1, STATUS_OK,       NONE_RSP);
    add_row(REQ_FENCE, 16'h0001, 32'd20,        32'd200,       1'b1, STATUS_MISMATCH, NONE_RSP);
    add_row(REQ_FENCE, 16'h0000, 32'd20,        32'd200,       1'b1, STATUS_OK,       11'd2);
    add_row(REQ_POP,   16'h0000, 32'd30,        32'd300,       1'b1, STATUS_OK,       11'd2);
    add_row(REQ_FIND,  16'h0000, 32'd15,        32'd0,         1'b0, STATUS_OK,       NONE_RSP);
    add_row(REQ_POP,   16'h0000, 32'd50,        32'hFFFF_FFFF, 1'b1, STATUS_OK,       11'd0);
    add_row(REQ_FIND,  16'h0000, 32'd15,        32'd0,         1'b0, STATUS_OK,       NONE_RSP);
    add_row(REQ_FIND,  16'h0000, 32'd25,        32'hFFFF_FFFF, 1'b0, STATUS_OK,       NONE_RSP);
    add_row(REQ_FIND,  16'h0000, 32'd0,         32'd0,         1'b0, STATUS_OK,       NONE_RSP);
    add_row(REQ_FIND,  16'h0000, 32'd50,        32'd0,         1'b0, STATUS_OK,       NONE_RSP);
    // a second root at the top of the exec space, split by a fence
    add_row(REQ_PUSH,  16'h8001, 32'hF000_0000, 32'h7FFF_FFFF, 1'b1, STATUS_OK,       11'd3);
    add_row(REQ_FENCE, 16'h8001, 32'hF800_0000, 32'hFFFF_FFFF, 1'b1, STATUS_OK,       11'd4);
    add_row(REQ_PUSH,  16'h7FFE, 32'hFC00_0000, 32'd0,         1'b1, STATUS_OK,       11'd5);
    add_row(REQ_POP,   16'h0000, 32'hFFFF_FFFF, 32'd1,         1'b1, STATUS_OK,       11'd5);
    add_row(REQ_POP,   16'h0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1, STATUS_OK,       11'd4);
    add_row(REQ_POP,   16'h0000, 32'd0,         32'd0,         1'b1, STATUS_NO_OPEN,  NONE_RSP);
    add_row(REQ_FIND,  16'h0000, 32'hFFFF_FFFE, 32'd0,         1'b0, STATUS_OK,       NONE_RSP);
    add_row(REQ_FIND,  16'h0000, 32'hFFFF_FFFF, 32'd0,         1'b0, STATUS_OK,       NONE_RSP);
    add_row(REQ_FIND,  16'h0000, 32'hF000_0000, 32'd0,         1'b0, STATUS_OK,       NONE_RSP);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    row = '0;
    // grow the tree first, then mixed traffic with noise
    repeat (BUILD_WORDS) begin
      row.word = make_word(1'b1);
      send_word(row);
    end
    repeat (RANDOM_WORDS) begin
      row.word = make_word(1'b0);
      send_word(row);
    end
    req_valid <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/nrt_pkg.sv
src/nrt_ram.sv
src/nrt_walk.sv
src/nested_range_table_core.sv
bench/tb_nested_range_table_core.sv
